// File: rtl/core/lcas_pkg.sv
package lcas_pkg;

  localparam int SIZE_W    = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [2:0] OP_WRITE  = 3'd0;
  localparam logic [2:0] OP_TOGGLE = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_INVERT = 3'd4;
  localparam logic [2:0] OP_STEP   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_EDGES  = 2'd2;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] col;
    logic [5:0] row;
    logic       cell_in;
  } cmd_t;

  typedef struct packed {
    logic       cell_out;
    logic [2:0] done_op;
  } result_t;

endpackage

// File: rtl/core/life_cellular_automaton_step.sv
// Write, toggle and read go through S_CELL; clear and invert sweep the rows in use in
// S_SWEEP; a generation runs over them in S_GEN; an unused op code is answered from
// idle. A new item can start in the cycle its predecessor's result shows.
// The simple dual-port row memory sets the pace: one row read and one row written per cycle.
// Synchronous reset clears the grid with a pass over all MAX_ROWS rows, busy meanwhile.
// Results cannot be stalled: each shows for one cycle with result_valid.
module life_cellular_automaton_step #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  lcas_pkg::cmd_t                     cmd,
  output lcas_pkg::result_t                  result,
  output logic                               result_valid,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lcas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lcas_pkg::SIZE_W-1:0]        cfg_data
);
  import lcas_pkg::*;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int CNT_W  = $clog2(MAX_ROWS + 4);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CELL,
    S_SWEEP,
    S_GEN
  } state_t;

  state_t state;

  logic [SIZE_W-1:0] grid_width;
  logic [SIZE_W-1:0] grid_height;
  logic              wrap_edges;

  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;
  logic [COL_W-1:0]  wm1;
  logic [CNT_W-1:0]  h_cnt;

  logic [CNT_W-1:0]  step;
  logic [2:0]        op_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_AW-1:0] row_q;
  logic              cell_in_q;
  logic              inside_q;

  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_data;
  logic                mem_we;
  logic [ROW_AW-1:0]   mem_waddr;
  logic [ROW_AW-1:0]   mem_raddr;
  logic [MAX_COLS-1:0] mem_wdata;

  logic [MAX_COLS-1:0] win_prev;
  logic [MAX_COLS-1:0] win_cur;
  logic [MAX_COLS-1:0] win_nxt;
  logic [MAX_COLS-1:0] first_row;

  logic [MAX_COLS-1:0] nb_row [3];
  logic [MAX_COLS-1:0] nb_w [3];
  logic [MAX_COLS-1:0] nb_e [3];
  logic [MAX_COLS-1:0] gen_row;
  logic [MAX_COLS-1:0] sweep_row;
  logic [MAX_COLS-1:0] cell_row;
  logic                top_zero;
  logic                bot_zero;
  logic                cmd_inside;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= SIZE_W'(64);
      grid_height <= SIZE_W'(64);
      wrap_edges  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height <= cfg_data;
        CFG_WRAP_EDGES:  wrap_edges  <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  // Zero acts as one, oversize saturates
  assign w_eff = (grid_width == '0) ? SIZE_W'(1) :
                 (int'(grid_width) > MAX_COLS) ? SIZE_W'(MAX_COLS) : grid_width;
  assign h_eff = (grid_height == '0) ? SIZE_W'(1) :
                 (int'(grid_height) > MAX_ROWS) ? SIZE_W'(MAX_ROWS) : grid_height;
  assign wm1   = COL_W'(w_eff - SIZE_W'(1));
  assign h_cnt = CNT_W'(h_eff);

  assign cmd_inside = ({1'b0, cmd.col} < w_eff) && ({1'b0, cmd.row} < h_eff);

  // Row memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // Cell update for write and toggle
  always_comb begin
    cell_row = rd_data;
    cell_row[col_q] = (op_q == OP_WRITE) ? cell_in_q : ~rd_data[col_q];
  end

  // Clear or invert the active columns of one row
  always_comb begin
    for (int x = 0; x < MAX_COLS; x++) begin
      if (x < int'(w_eff)) begin
        sweep_row[x] = (op_q == OP_CLEAR) ? 1'b0 : ~rd_data[x];
      end else begin
        sweep_row[x] = rd_data[x];
      end
    end
  end

  // Generation: window holds old rows y-1, y, y+1
  assign top_zero = !wrap_edges && (step == CNT_W'(4));
  assign bot_zero = !wrap_edges && (step == h_cnt + CNT_W'(3));

  always_comb begin
    nb_row[0] = top_zero ? '0 : win_prev;
    nb_row[1] = win_cur;
    nb_row[2] = bot_zero ? '0 : win_nxt;
    for (int r = 0; r < 3; r++) begin
      nb_w[r] = nb_row[r] << 1;
      nb_w[r][0] = wrap_edges & nb_row[r][wm1];
      nb_e[r] = nb_row[r] >> 1;
      nb_e[r][wm1] = wrap_edges & nb_row[r][0];
    end
  end

  always_comb begin
    logic [3:0] cnt;
    cnt = '0;
    for (int x = 0; x < MAX_COLS; x++) begin
      cnt = 4'(nb_w[0][x]) + 4'(nb_row[0][x]) + 4'(nb_e[0][x])
          + 4'(nb_w[1][x]) + 4'(nb_e[1][x])
          + 4'(nb_w[2][x]) + 4'(nb_row[2][x]) + 4'(nb_e[2][x]);
      if (x < int'(w_eff)) begin
        gen_row[x] = win_cur[x] ? (cnt == 4'd2 || cnt == 4'd3) : (cnt == 4'd3);
      end else begin
        gen_row[x] = win_cur[x];
      end
    end
  end

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = ROW_AW'(step);
      end
      S_IDLE: begin
        mem_raddr = ROW_AW'(cmd.row);
      end
      S_CELL: begin
        mem_we    = inside_q && (op_q == OP_WRITE || op_q == OP_TOGGLE);
        mem_waddr = row_q;
        mem_wdata = cell_row;
      end
      S_SWEEP: begin
        mem_raddr = ROW_AW'(step);
        mem_we    = (step != '0);
        mem_waddr = ROW_AW'(step - CNT_W'(1));
        mem_wdata = sweep_row;
      end
      S_GEN: begin
        mem_raddr = (step == '0) ? ROW_AW'(h_eff - SIZE_W'(1))
                                 : ROW_AW'(step - CNT_W'(1));
        mem_we    = (step >= CNT_W'(4));
        mem_waddr = ROW_AW'(step - CNT_W'(4));
        mem_wdata = gen_row;
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        S_INIT: begin
          result_valid <= 1'b0;
          if (step == CNT_W'(MAX_ROWS - 1)) begin
            step  <= '0;
            state <= S_IDLE;
          end else begin
            step <= step + CNT_W'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            op_q      <= cmd.op;
            col_q     <= COL_W'(cmd.col);
            row_q     <= ROW_AW'(cmd.row);
            cell_in_q <= cmd.cell_in;
            inside_q  <= cmd_inside;
            step      <= '0;
            unique case (cmd.op)
              OP_WRITE, OP_TOGGLE, OP_READ: begin
                result_valid <= 1'b0;
                state        <= S_CELL;
              end
              OP_CLEAR, OP_INVERT: begin
                result_valid <= 1'b0;
                state        <= S_SWEEP;
              end
              OP_STEP: begin
                result_valid <= 1'b0;
                state        <= S_GEN;
              end
              default: begin
                result_valid     <= 1'b1;
                result.cell_out  <= 1'b0;
                result.done_op   <= cmd.op;
              end
            endcase
          end else begin
            result_valid <= 1'b0;
          end
        end
        S_CELL: begin
          result_valid    <= 1'b1;
          result.cell_out <= (op_q == OP_READ) && inside_q && rd_data[col_q];
          result.done_op  <= op_q;
          state           <= S_IDLE;
        end
        S_SWEEP: begin
          step <= step + CNT_W'(1);
          if (step == h_cnt) begin
            result_valid    <= 1'b1;
            result.cell_out <= 1'b0;
            result.done_op  <= op_q;
            state           <= S_IDLE;
          end else begin
            result_valid <= 1'b0;
          end
        end
        S_GEN: begin
          step <= step + CNT_W'(1);
          // advance the row window
          if (step != '0 && step <= h_cnt + CNT_W'(1)) begin
            win_prev <= win_cur;
            win_cur  <= win_nxt;
            win_nxt  <= rd_data;
          end else if (step == h_cnt + CNT_W'(2)) begin
            win_prev <= win_cur;
            win_cur  <= win_nxt;
            win_nxt  <= first_row;
          end
          // hold old row 0 for the wrap below the last row
          if (step == CNT_W'(2)) begin
            first_row <= rd_data;
          end
          if (step == h_cnt + CNT_W'(3)) begin
            result_valid    <= 1'b1;
            result.cell_out <= 1'b0;
            result.done_op  <= op_q;
            state           <= S_IDLE;
          end else begin
            result_valid <= 1'b0;
          end
        end
        default: begin
          result_valid <= 1'b0;
          state        <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/lcas_checker.sv
module lcas_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input lcas_pkg::cmd_t                 cmd,
  input lcas_pkg::result_t              result,
  input logic                           result_valid,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [lcas_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [lcas_pkg::SIZE_W-1:0]    cfg_data
);
  import lcas_pkg::*;

  // an accepted item either starts work or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || result_valid)
    else $error("accepted item neither started nor answered");

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result shown while still busy");

  a_undef_echo: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.op > OP_STEP
      |=> result_valid && result.done_op == $past(cmd.op) && !result.cell_out)
    else $error("unused op code not echoed in the next cycle");

  a_cell_out_read_only: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.done_op != OP_READ |-> !result.cell_out)
    else $error("cell_out set for an op other than read");

endmodule

bind life_cellular_automaton_step lcas_checker u_lcas_checker (.*);
